[hdl/rfid_pkg.sv]
// ----------------------------------------------------------------------------
// rfid_pkg: shared types of the random free id allocator
// Command codes, sequencer states, field widths and the divider result.
// ----------------------------------------------------------------------------
package rfid_pkg;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned RND_W   = 23;
  localparam int unsigned AVAIL_W = 16;
  localparam int unsigned DIVD_W  = 23;
  localparam int unsigned DIVS_W  = 16;
  localparam int unsigned STEP_W  = 5;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_QUERY   = 2'd1,
    CMD_RESERVE = 2'd2,
    CMD_FREE    = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIV,
    ST_WALK,
    ST_ROWRD,
    ST_ROWLD,
    ST_SCAN,
    ST_APPLY,
    ST_MARK,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic              done;
    logic [DIVS_W-1:0] rem;
  } div_res_t;

endpackage

[hdl/rfid_if.sv]
// ----------------------------------------------------------------------------
// rfid_cmd_if / rfid_res_if: command and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rfid_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] id_net_order;
  logic [22:0] random_value;

  modport source (output valid, output cmd, output id_net_order, output random_value,
                  input ready);
  modport sink   (input valid, input cmd, input id_net_order, input random_value,
                  output ready);
endinterface

interface rfid_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] allocated_id;
  logic        used_flag;

  modport source (output valid, output allocated_id, output used_flag, input ready);
  modport sink   (input valid, input allocated_id, input used_flag, output ready);
endinterface

[hdl/random_free_id_bitmap_allocator_unit.sv]
// ----------------------------------------------------------------------------
// random_free_id_bitmap_allocator_unit: random free id allocator
// Used-id bitmap with per-group free counts, driven by a small sequencer.
// ----------------------------------------------------------------------------
// The block keeps one used bit per id in a RAM of one row per group, a free
// count per group in a second RAM, and the number of free ids below the
// reserved base in a register. After reset a clearing pass writes every row
// and count before the first command beat is taken. Commands are handled one
// at a time. Query, reserve and free take the group of the id from a constant
// reciprocal multiply on the accepting edge and its bit from the group, then
// read the row, apply it and deliver the result. Allocate first takes the
// random value modulo the available count in the divider, then walks the
// group counts at one group a cycle, then scans the chosen row at one bit a
// cycle. Ids 0 and ID_SPACE-1 are never handed out, and an allocate with no
// id available returns 0.
module random_free_id_bitmap_allocator_unit #(
  parameter int unsigned ID_SPACE      = 65536,
  parameter int unsigned GROUP_BITS    = 64,
  parameter int unsigned RESERVED_BASE = 65472
) (
  input  logic clk_i,
  input  logic rst_ni,
  rfid_cmd_if.sink   in_i,
  rfid_res_if.source out_o
);
  import rfid_pkg::*;

  localparam int unsigned NUM_GROUPS = (ID_SPACE + GROUP_BITS - 1) / GROUP_BITS;
  localparam int unsigned LAST_N     = ID_SPACE - (NUM_GROUPS - 1) * GROUP_BITS;
  localparam int unsigned G_W        = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int unsigned GC_W       = $clog2(NUM_GROUPS + 1);
  localparam int unsigned O_W        = $clog2(GROUP_BITS);
  localparam int unsigned OC_W       = $clog2(GROUP_BITS + 1);
  localparam int unsigned CNT_W      = $clog2(GROUP_BITS + 1);
  // Reciprocal of GROUP_BITS, exact for every 16-bit id.
  localparam int unsigned REC_SH     = ID_W + O_W;
  localparam int unsigned REC_M      = ((1 << REC_SH) + GROUP_BITS - 1) / GROUP_BITS;
  localparam int unsigned PROD_W     = 2 * ID_W + 1;

  state_e state_q, state_d;

  cmd_e                  cmd_q;
  logic [ID_W-1:0]       id_q;
  logic [AVAIL_W-1:0]    avail_q;
  logic [AVAIL_W-1:0]    r_q;
  logic [AVAIL_W:0]      acc_q;
  logic [G_W-1:0]        g_q;
  logic [GC_W-1:0]       walk_q;
  logic                  pend_q;
  logic [G_W-1:0]        pend_g_q;
  logic [OC_W-1:0]       off_q;
  logic [GROUP_BITS-1:0] row_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [ID_W-1:0]       res_id_q;
  logic                  res_flag_q;
  logic                  out_valid_q;
  logic [ID_W-1:0]       out_id_q;
  logic                  out_flag_q;

  // Incoming id with its bytes swapped into host order.
  logic [ID_W-1:0] in_id;
  logic            in_id_special;
  logic            accept;
  cmd_e            in_cmd;

  assign in_id         = {in_i.id_net_order[7:0], in_i.id_net_order[15:8]};
  assign in_id_special = (in_id == '0) || ({1'b0, in_id} >= 17'(ID_SPACE - 1));
  assign in_i.ready    = (state_q == ST_IDLE);
  assign accept        = in_i.valid && in_i.ready;
  assign in_cmd        = cmd_e'(in_i.cmd);

  // Group of the incoming id, and the bit offset of the held id once its
  // group is registered.
  logic [PROD_W-1:0] in_grp_prod;
  logic [G_W-1:0]    in_grp;
  logic [ID_W-1:0]   id_off;

  assign in_grp_prod = PROD_W'(in_id) * PROD_W'(REC_M);
  assign in_grp      = in_grp_prod[REC_SH +: G_W];
  assign id_off      = id_q - ID_W'(g_q) * ID_W'(GROUP_BITS);

  // Divider: reduces the random value modulo the available count.
  div_res_t div_res;
  logic     div_start;

  assign div_start = accept && (in_cmd == CMD_ALLOC) && (avail_q != '0);

  rfid_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(in_i.random_value),
    .divisor_i (avail_q),
    .res_o     (div_res)
  );

  // Group walk: the count RAM is read one group ahead of the compare.
  logic             walk_issue;
  logic [AVAIL_W:0] walk_sum;
  logic             walk_hit;
  logic             walk_fail;
  logic [CNT_W-1:0] cnt_rdata;

  assign walk_issue = (state_q == ST_WALK) && (walk_q < GC_W'(NUM_GROUPS));
  assign walk_sum   = acc_q + (AVAIL_W + 1)'(cnt_rdata);
  assign walk_hit   = pend_q && (walk_sum > {1'b0, r_q});
  assign walk_fail  = !pend_q && !walk_issue;

  // Row scan and update helpers.
  logic [O_W-1:0]        bit_idx;
  logic                  cur_bit;
  logic                  scan_end;
  logic [GROUP_BITS-1:0] bit_mask;
  logic [ID_W:0]         id_full;
  logic                  mark_set;

  assign bit_idx  = off_q[O_W-1:0];
  assign scan_end = (off_q == OC_W'(GROUP_BITS));
  assign cur_bit  = row_q[bit_idx];
  assign bit_mask = {{(GROUP_BITS-1){1'b0}}, 1'b1} << bit_idx;
  assign id_full  = (ID_W + 1)'(g_q) * (ID_W + 1)'(GROUP_BITS) + (ID_W + 1)'(off_q);
  assign mark_set = (cmd_q != CMD_FREE);

  // Clearing-pass contents: ids 0 and ID_SPACE-1 are used, and the bits of a
  // partial last group that lie beyond the id space read as used so that the
  // scan skips them.
  logic [GROUP_BITS-1:0] init_row;
  logic [CNT_W-1:0]      init_cnt;
  logic [G_W-1:0]        init_g;

  assign init_g = walk_q[G_W-1:0];

  always_comb begin
    init_row = '0;
    init_cnt = CNT_W'(GROUP_BITS);
    if (init_g == G_W'(NUM_GROUPS - 1)) begin
      init_cnt = CNT_W'(LAST_N - 1);
      for (int i = 0; i < GROUP_BITS; i++) begin
        if (i >= LAST_N - 1) begin
          init_row[i] = 1'b1;
        end
      end
    end
    if (init_g == '0) begin
      init_row[0] = 1'b1;
      init_cnt    = init_cnt - CNT_W'(1);
    end
  end

  // RAM ports.
  logic                  mem_we;
  logic [G_W-1:0]        mem_waddr;
  logic [GROUP_BITS-1:0] row_wdata;
  logic [CNT_W-1:0]      cnt_wdata;
  logic [GROUP_BITS-1:0] row_rdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = g_q;
    row_wdata = mark_set ? (row_q | bit_mask) : (row_q & ~bit_mask);
    if (mark_set) begin
      cnt_wdata = (cnt_q != '0) ? cnt_q - CNT_W'(1) : cnt_q;
    end else begin
      cnt_wdata = cnt_q + CNT_W'(1);
    end
    if (state_q == ST_INIT) begin
      mem_we    = 1'b1;
      mem_waddr = init_g;
      row_wdata = init_row;
      cnt_wdata = init_cnt;
    end else if (state_q == ST_MARK) begin
      mem_we = 1'b1;
    end
  end

  rfid_ram #(.WIDTH(GROUP_BITS), .DEPTH(NUM_GROUPS)) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(row_wdata),
    .raddr_i(g_q),
    .rdata_o(row_rdata)
  );

  rfid_ram #(.WIDTH(CNT_W), .DEPTH(NUM_GROUPS)) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(cnt_wdata),
    .raddr_i(walk_issue ? walk_q[G_W-1:0] : g_q),
    .rdata_o(cnt_rdata)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (walk_q == GC_W'(NUM_GROUPS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_ALLOC) begin
            state_d = div_start ? ST_DIV : ST_FIN;
          end else begin
            state_d = in_id_special ? ST_FIN : ST_ROWRD;
          end
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_hit) begin
          state_d = ST_ROWRD;
        end else if (walk_fail) begin
          state_d = ST_FIN;
        end
      end
      ST_ROWRD: state_d = ST_ROWLD;
      ST_ROWLD: state_d = (cmd_q == CMD_ALLOC) ? ST_SCAN : ST_APPLY;
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_FIN;
        end else if (!cur_bit && (r_q == '0)) begin
          state_d = ST_MARK;
        end
      end
      ST_APPLY: begin
        unique case (cmd_q)
          CMD_RESERVE: state_d = cur_bit ? ST_FIN : ST_MARK;
          CMD_FREE:    state_d = cur_bit ? ST_MARK : ST_FIN;
          default:     state_d = ST_FIN;
        endcase
      end
      ST_MARK: state_d = ST_FIN;
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      walk_q      <= '0;
      pend_q      <= 1'b0;
      avail_q     <= AVAIL_W'(RESERVED_BASE - 1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_INIT) begin
        walk_q <= walk_q + GC_W'(1);
      end else if (state_q == ST_DIV) begin
        walk_q <= '0;
        pend_q <= 1'b0;
      end else if (state_q == ST_WALK) begin
        pend_q <= walk_issue;
        if (walk_issue) begin
          walk_q <= walk_q + GC_W'(1);
        end
      end
      if (state_q == ST_MARK && id_full < (ID_W + 1)'(RESERVED_BASE)) begin
        if (mark_set && avail_q != '0) begin
          avail_q <= avail_q - AVAIL_W'(1);
        end else if (!mark_set && avail_q != '1) begin
          avail_q <= avail_q + AVAIL_W'(1);
        end
      end
      if (state_q == ST_FIN && state_d == ST_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= in_cmd;
      id_q       <= in_id;
      g_q        <= in_grp;
      res_id_q   <= '0;
      res_flag_q <= 1'b0;
    end
    if (state_q == ST_DIV && div_res.done) begin
      acc_q <= '0;
      r_q   <= div_res.rem;
    end
    if (state_q == ST_WALK) begin
      pend_g_q <= walk_q[G_W-1:0];
      if (walk_hit) begin
        r_q   <= r_q - acc_q[AVAIL_W-1:0];
        g_q   <= pend_g_q;
        off_q <= '0;
      end else if (pend_q) begin
        acc_q <= walk_sum;
      end
    end
    if (state_q == ST_ROWRD && cmd_q != CMD_ALLOC) begin
      off_q <= OC_W'(id_off);
    end
    if (state_q == ST_ROWLD) begin
      row_q <= row_rdata;
      cnt_q <= cnt_rdata;
    end
    if (state_q == ST_SCAN && !scan_end && !(!cur_bit && r_q == '0)) begin
      off_q <= off_q + OC_W'(1);
      if (!cur_bit) begin
        r_q <= r_q - AVAIL_W'(1);
      end
    end
    if (state_q == ST_APPLY && cmd_q == CMD_QUERY) begin
      // The id was checked against the always-reserved ids on entry.
      res_flag_q <= cur_bit && (id_q != '0);
    end
    if (state_q == ST_MARK && cmd_q == CMD_ALLOC) begin
      res_id_q <= id_full[ID_W-1:0];
    end
    if (state_q == ST_FIN && state_d == ST_IDLE) begin
      out_id_q   <= res_id_q;
      out_flag_q <= res_flag_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.allocated_id = out_id_q;
  assign out_o.used_flag    = out_flag_q;

endmodule

[hdl/rfid_ram.sv]
// ----------------------------------------------------------------------------
// rfid_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rfid_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hdl/rfid_div.sv]
// ----------------------------------------------------------------------------
// rfid_div: iterative restoring divider
// One quotient bit per cycle; result is flagged by a one-cycle done pulse.
// ----------------------------------------------------------------------------
module rfid_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rfid_pkg::DIVD_W-1:0] dividend_i,
  input  logic [rfid_pkg::DIVS_W-1:0] divisor_i,
  output rfid_pkg::div_res_t        res_o
);
  import rfid_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [DIVS_W-1:0] div_q;
  logic [DIVS_W-1:0] rem_q;
  logic [DIVD_W-1:0] quo_q;
  logic [DIVS_W:0]   trial;
  logic              fits;

  assign trial = {rem_q, quo_q[DIVD_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == STEP_W'(DIVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? DIVS_W'(trial - {1'b0, div_q}) : trial[DIVS_W-1:0];
      quo_q <= {quo_q[DIVD_W-2:0], fits};
    end
  end

  assign res_o.done = done_q;
  assign res_o.rem  = rem_q;

endmodule

[hdl/rfid_chk.sv]
// ----------------------------------------------------------------------------
// rfid_chk: port-level checks of the id allocator
// Watches the command and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module rfid_chk #(
  parameter int unsigned ID_SPACE = 65536
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] allocated_id_i,
  input logic        used_flag_i
);

  // A result beat that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // Commands are handled one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second command taken while one is in flight");

  // A result answers either an allocate or a query, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && used_flag_i |-> allocated_id_i == '0)
    else $error("result carries both an id and a used flag");

  // The top id of the space is never handed out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> {1'b0, allocated_id_i} != 17'(ID_SPACE - 1))
    else $error("always-reserved id allocated");

endmodule

bind random_free_id_bitmap_allocator_unit rfid_chk #(.ID_SPACE(ID_SPACE)) u_rfid_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .allocated_id_i(out_o.allocated_id),
  .used_flag_i   (out_o.used_flag)
);

[tb/sv/tb_random_free_id_bitmap_allocator_unit.sv]
// ----------------------------------------------------------------------------
// tb_random_free_id_bitmap_allocator_unit: self-checking bench of the allocator
// Drives command beats with random gaps, predicts every result from a local
// bitmap model and compares each result beat field by field, in order.
// ----------------------------------------------------------------------------
module tb_random_free_id_bitmap_allocator_unit;
  import rfid_pkg::*;

  localparam int unsigned SPACE  = 65536;
  localparam int unsigned GBITS  = 64;
  localparam int unsigned RBASE  = 65472;
  localparam int unsigned NGRP   = SPACE / GBITS;
  localparam int unsigned NRAND  = 500;
  localparam int unsigned NDIR   = 20;

  typedef struct packed {
    logic [15:0] alloc_id;
    logic        used;
  } answer_t;

  typedef struct packed {
    cmd_e        op;
    logic [15:0] id_net;
    logic [22:0] rnd;
    logic        typed;
    answer_t     ans;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rfid_cmd_if cmd_ch();
  rfid_res_if res_ch();

  random_free_id_bitmap_allocator_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_ch.sink),
    .out_o (res_ch.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Local copy of the allocator state.
  bit          id_used [SPACE];
  int unsigned grp_free [NGRP];
  int unsigned free_below_base;

  // Expected answers waiting for their result beat. A typed-in answer, where a
  // row has one, must agree with the prediction too.
  answer_t     pending_answers [$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned allocs_seen = 0;
  bit          sending_done = 1'b0;
  bit          calm_phase = 1'b0;
  bit          hold_off_req = 1'b0;
  bit          hold_off_done = 1'b0;

  function automatic bit is_fixed_reserved(int unsigned id);
    return id == 0 || id >= SPACE - 1;
  endfunction

  function automatic void set_used(int unsigned id, bit val);
    int unsigned g;
    g = id / GBITS;
    if (is_fixed_reserved(id)) return;
    if (val) begin
      if (id_used[id]) return;
      id_used[id] = 1'b1;
      if (id < RBASE && free_below_base > 0) free_below_base--;
      if (grp_free[g] > 0) grp_free[g]--;
    end else begin
      if (!id_used[id]) return;
      id_used[id] = 1'b0;
      if (id < RBASE && free_below_base < 65535) free_below_base++;
      grp_free[g]++;
    end
  endfunction

  function automatic void clear_bitmap();
    for (int unsigned i = 0; i < SPACE; i++) id_used[i] = 1'b0;
    for (int unsigned g = 0; g < NGRP; g++) grp_free[g] = GBITS;
    id_used[0] = 1'b1;
    id_used[SPACE-1] = 1'b1;
    grp_free[0]--;
    grp_free[NGRP-1]--;
    free_below_base = RBASE - 1;
  endfunction

  // Picks the r-th free id, walking group counts first and then the row.
  function automatic logic [15:0] pick_free_id(logic [22:0] rnd);
    int unsigned r, acc;
    acc = 0;
    if (free_below_base == 0) return '0;
    r = rnd % free_below_base;
    for (int unsigned g = 0; g < NGRP; g++) begin
      if (acc + grp_free[g] <= r) begin
        acc += grp_free[g];
        continue;
      end
      r -= acc;
      for (int unsigned id = g * GBITS; id < g * GBITS + GBITS; id++) begin
        if (!id_used[id]) begin
          if (r == 0) begin
            set_used(id, 1'b1);
            return id[15:0];
          end
          r--;
        end
      end
      break;
    end
    return '0;
  endfunction

  function automatic answer_t apply_command(cmd_e op, logic [15:0] id_net,
                                            logic [22:0] rnd);
    answer_t     a;
    int unsigned id;
    a = '0;
    id = {id_net[7:0], id_net[15:8]};
    case (op)
      CMD_ALLOC:   a.alloc_id = pick_free_id(rnd);
      CMD_QUERY:   a.used = is_fixed_reserved(id) ? 1'b0 : id_used[id];
      CMD_RESERVE: set_used(id, 1'b1);
      default:     set_used(id, 1'b0);
    endcase
    return a;
  endfunction

  function automatic logic [15:0] to_net(int unsigned id);
    return {id[7:0], id[15:8]};
  endfunction

  // Directed rows: the fixed reserved ids, the edges of the reserved range,
  // double reserve and double free, and allocate at the random extremes.
  row_t directed_rows [NDIR];
  initial begin
    directed_rows[0]  = '{CMD_QUERY,   to_net(0),     23'd0,         1'b1, '{16'd0, 1'b0}};
    directed_rows[1]  = '{CMD_QUERY,   to_net(65535), 23'd0,         1'b1, '{16'd0, 1'b0}};
    directed_rows[2]  = '{CMD_RESERVE, to_net(0),     23'd0,         1'b1, '{16'd0, 1'b0}};
    directed_rows[3]  = '{CMD_FREE,    to_net(65535), 23'd0,         1'b1, '{16'd0, 1'b0}};
    directed_rows[4]  = '{CMD_QUERY,   to_net(0),     23'd0,         1'b1, '{16'd0, 1'b0}};
    directed_rows[5]  = '{CMD_ALLOC,   16'hffff,      23'd0,         1'b1, '{16'd1, 1'b0}};
    directed_rows[6]  = '{CMD_QUERY,   to_net(1),     23'h7fffff,    1'b1, '{16'd0, 1'b1}};
    directed_rows[7]  = '{CMD_ALLOC,   16'h0000,      23'h7fffff,    1'b0, '0};
    directed_rows[8]  = '{CMD_RESERVE, to_net(65534), 23'h7fffff,    1'b1, '{16'd0, 1'b0}};
    directed_rows[9]  = '{CMD_QUERY,   to_net(65534), 23'd0,         1'b1, '{16'd0, 1'b1}};
    directed_rows[10] = '{CMD_RESERVE, to_net(65534), 23'd0,         1'b1, '{16'd0, 1'b0}};
    directed_rows[11] = '{CMD_FREE,    to_net(65534), 23'd0,         1'b1, '{16'd0, 1'b0}};
    directed_rows[12] = '{CMD_FREE,    to_net(65534), 23'd0,         1'b1, '{16'd0, 1'b0}};
    directed_rows[13] = '{CMD_RESERVE, to_net(RBASE), 23'd0,         1'b1, '{16'd0, 1'b0}};
    directed_rows[14] = '{CMD_RESERVE, to_net(RBASE-1), 23'd0,       1'b1, '{16'd0, 1'b0}};
    directed_rows[15] = '{CMD_QUERY,   to_net(RBASE-1), 23'd0,       1'b1, '{16'd0, 1'b1}};
    directed_rows[16] = '{CMD_FREE,    to_net(1),     23'd0,         1'b1, '{16'd0, 1'b0}};
    directed_rows[17] = '{CMD_ALLOC,   16'h5a5a,      23'd63,        1'b0, '0};
    directed_rows[18] = '{CMD_QUERY,   16'hffff,      23'd0,         1'b1, '{16'd0, 1'b0}};
    directed_rows[19] = '{CMD_ALLOC,   16'h1234,      23'h400000,    1'b0, '0};
  end

  // Hands one beat to the block and records its predicted answer at the
  // accepting edge. Gaps come in bursts before the beat unless calm. Valid
  // stays up after the accepting edge until the next beat, a gap or the end of sending replaces it.
  task automatic send_beat(cmd_e op, logic [15:0] id_net, logic [22:0] rnd,
                           bit typed, answer_t typed_ans);
    answer_t a;
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.cmd          <= op;
    cmd_ch.id_net_order <= id_net;
    cmd_ch.random_value <= rnd;
    do @(posedge clk_i); while (!cmd_ch.ready);
    a = apply_command(op, id_net, rnd);
    if (typed && a !== typed_ans) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("predictor disagrees with table: op %s table %h model %h",
                 op.name(), typed_ans, a);
    end
    pending_answers.push_back(a);
    @(negedge clk_i);
  endtask

  // Random ids lean toward recently touched ids so that reserve, free and
  // query hit used entries, with some wholly random and some edge ids.
  int unsigned recent_ids [$];

  function automatic int unsigned pick_id();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 5 && recent_ids.size() > 0)
      return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
    if (k == 5) return RBASE + $urandom_range(0, SPACE - 1 - RBASE);
    if (k == 6) return $urandom_range(0, 1) ? 0 : SPACE - 1;
    return $urandom_range(0, SPACE - 1);
  endfunction

  initial begin
    cmd_e        op;
    int unsigned id;
    cmd_ch.valid        = 1'b0;
    cmd_ch.cmd          = CMD_ALLOC;
    cmd_ch.id_net_order = '0;
    cmd_ch.random_value = '0;
    clear_bitmap();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    for (int i = 0; i < NDIR; i++)
      send_beat(directed_rows[i].op, directed_rows[i].id_net, directed_rows[i].rnd,
                directed_rows[i].typed, directed_rows[i].ans);
    for (int i = 0; i < NRAND; i++) begin
      if (i == NRAND / 3) hold_off_req = 1'b1;
      if (i == NRAND - 60) calm_phase = 1'b1;
      op = cmd_e'($urandom_range(0, 3));
      id = pick_id();
      if (op != CMD_ALLOC && op != CMD_QUERY) recent_ids.push_back(id);
      if (recent_ids.size() > 32) void'(recent_ids.pop_front());
      send_beat(op, to_net(id), 23'($urandom_range(0, 23'h7fffff)), 1'b0, '0);
    end
    cmd_ch.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Result side: random stalls, one long hold-off started while commands are still being sent.
  initial begin
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        res_ch.ready <= 1'b0;
        hold_off_done = 1'b1;
        for (int unsigned n = 0; n < 6000; n++) @(negedge clk_i);
      end
      if (!calm_phase && $urandom_range(0, 7) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end
      res_ch.ready <= 1'b1;
    end
  end

  // Result checker, at the rising edge.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result beat with nothing expected: id %h flag %b",
                   res_ch.allocated_id, res_ch.used_flag);
      end else begin
        want = pending_answers.pop_front();
        if (want.alloc_id != 0) allocs_seen++;
        if (res_ch.allocated_id !== want.alloc_id || res_ch.used_flag !== want.used) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch on beat %0d: expected id %h flag %b, got id %h flag %b",
                     results_seen, want.alloc_id, want.used,
                     res_ch.allocated_id, res_ch.used_flag);
        end
      end
    end
  end

  initial begin
    wait (sending_done && pending_answers.size() == 0);
    repeat (2000) @(posedge clk_i);
    if (pending_answers.size() != 0) mismatch_count++;
    $display("covered %0d command beats and %0d results, %0d ids handed out",
             NDIR + NRAND, results_seen, allocs_seen);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("tb: failure");
    end
    $finish;
  end

  // Timeout for the slowest run, with its stalls and the clearing pass.
  initial begin
    #8000000;
    $display("timeout with %0d results outstanding", pending_answers.size());
    $display("tb: failure");
    $finish;
  end

endmodule
